>>> sv/sdi_pkg.sv
// ----------------------------------------------------------------------------
// sdi_pkg
// Shared types and constants of the SD card SPI-mode init sequencer: phase
// and command codes, register and result records, and the command frames.
// ----------------------------------------------------------------------------
package sdi_pkg;

    // Sequencer phase
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_CLOCKS = 3'd1,
        PH_CMD    = 3'd2,
        PH_RESP   = 3'd3,
        PH_DATA   = 3'd4,
        PH_DONE   = 3'd5
    } t_phase;

    // Command in flight
    typedef enum logic [2:0] {
        CMD_GO_IDLE  = 3'd0,
        CMD_IF_COND  = 3'd1,
        CMD_APP      = 3'd2,
        CMD_OP_COND  = 3'd3,
        CMD_READ_OCR = 3'd4
    } t_cmd;

    // Failure codes
    localparam logic [2:0] FAIL_NONE    = 3'd0;
    localparam logic [2:0] FAIL_IDLE    = 3'd1;
    localparam logic [2:0] FAIL_IF_COND = 3'd2;
    localparam logic [2:0] FAIL_OP_COND = 3'd3;
    localparam logic [2:0] FAIL_OCR     = 3'd4;

    // Card kinds
    localparam logic [1:0] KIND_UNKNOWN = 2'd0;
    localparam logic [1:0] KIND_V1      = 2'd1;
    localparam logic [1:0] KIND_V2      = 2'd2;
    localparam logic [1:0] KIND_HC      = 2'd3;

    // Register indexes
    localparam logic [1:0] REG_GO_IDLE_TRIES   = 2'd0;
    localparam logic [1:0] REG_INTERFACE_TRIES = 2'd1;
    localparam logic [1:0] REG_OP_COND_TRIES   = 2'd2;
    localparam logic [1:0] REG_POLL_LIMIT      = 2'd3;

    // Byte constants
    localparam logic [7:0] BYTE_IDLE     = 8'hFF;
    localparam logic [7:0] CMD_START_BIT = 8'h40;
    localparam logic [7:0] R1_IDLE       = 8'h01;
    localparam logic [7:0] R1_READY      = 8'h00;
    localparam logic [7:0] ECHO_PATTERN  = 8'hAA;
    localparam logic [3:0] INIT_CLOCK_BYTES = 4'd10;
    localparam logic [3:0] FRAME_END_INDEX  = 4'd7;
    localparam logic [3:0] DATA_LAST_INDEX  = 4'd3;

    typedef struct packed {
        logic [3:0] go_idle_tries;
        logic [3:0] interface_tries;
        logic [3:0] op_cond_tries;
        logic [4:0] poll_limit;
    } t_cfg;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       chip_select;
        logic       done_res;
        logic       success;
        logic [1:0] card_type;
        logic [2:0] fail_code;
    } t_result;

    // Command frame byte: index byte, four argument bytes, CRC byte
    function automatic logic [7:0] frame_byte(t_cmd cmd, logic [2:0] idx);
        logic [7:0] b;
        b = 8'h00;
        case (cmd)
            CMD_GO_IDLE: begin
                case (idx)
                    3'd0:    b = 8'd0;
                    3'd5:    b = 8'h95;
                    default: b = 8'h00;
                endcase
            end
            CMD_IF_COND: begin
                case (idx)
                    3'd0:    b = 8'd8;
                    3'd3:    b = 8'h01;
                    3'd4:    b = 8'hAA;
                    3'd5:    b = 8'h87;
                    default: b = 8'h00;
                endcase
            end
            CMD_APP: begin
                case (idx)
                    3'd0:    b = 8'd55;
                    3'd5:    b = 8'h65;
                    default: b = 8'h00;
                endcase
            end
            CMD_OP_COND: begin
                case (idx)
                    3'd0:    b = 8'd41;
                    3'd1:    b = 8'h40;
                    3'd5:    b = 8'h77;
                    default: b = 8'h00;
                endcase
            end
            CMD_READ_OCR: begin
                case (idx)
                    3'd0:    b = 8'd58;
                    3'd5:    b = 8'hFD;
                    default: b = 8'h00;
                endcase
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

>>> sv/sdi_cfg_regs.sv
// ----------------------------------------------------------------------------
// sdi_cfg_regs
// APB register file: retry counts and poll limit of the init sequencer.
// ----------------------------------------------------------------------------
module sdi_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output sdi_pkg::t_cfg o_cfg
);
    import sdi_pkg::*;

    t_cfg       r_cfg;
    logic       w_wr;
    logic [1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[3:2];

    // Write the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.go_idle_tries   <= 4'd8;
            r_cfg.interface_tries <= 4'd10;
            r_cfg.op_cond_tries   <= 4'd8;
            r_cfg.poll_limit      <= 5'd16;
        end else if (w_wr) begin
            case (w_idx)
                REG_GO_IDLE_TRIES:   r_cfg.go_idle_tries   <= pwdata[3:0];
                REG_INTERFACE_TRIES: r_cfg.interface_tries <= pwdata[3:0];
                REG_OP_COND_TRIES:   r_cfg.op_cond_tries   <= pwdata[3:0];
                REG_POLL_LIMIT:      r_cfg.poll_limit      <= pwdata[4:0];
                default:             r_cfg.poll_limit      <= r_cfg.poll_limit;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (w_idx)
            REG_GO_IDLE_TRIES:   prdata = {28'd0, r_cfg.go_idle_tries};
            REG_INTERFACE_TRIES: prdata = {28'd0, r_cfg.interface_tries};
            REG_OP_COND_TRIES:   prdata = {28'd0, r_cfg.op_cond_tries};
            REG_POLL_LIMIT:      prdata = {27'd0, r_cfg.poll_limit};
            default:             prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> sv/sdi_core.sv
// ----------------------------------------------------------------------------
// sdi_core
// Sequencer state and its one-beat step: from the held input beat and the
// current state, form the next state and the result beat.
// ----------------------------------------------------------------------------
module sdi_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_start,
    input  logic [7:0]       i_rx_byte,
    input  sdi_pkg::t_cfg    i_cfg,
    output sdi_pkg::t_result o_result
);
    import sdi_pkg::*;

    t_phase     r_phase,      n_phase;
    t_cmd       r_cmd,        n_cmd;
    logic [3:0] r_byte_index, n_byte_index;
    logic [3:0] r_try_count,  n_try_count;
    logic [4:0] r_poll_count, n_poll_count;
    logic [1:0] r_card_kind,  n_card_kind;
    logic       r_selected,   n_selected;
    logic       r_echo,       n_echo;
    logic       r_high_cap,   n_high_cap;
    logic       r_final_ok,   n_final_ok;
    logic [2:0] r_final_fail, n_final_fail;

    logic [3:0] w_try_inc;
    logic [3:0] w_bi_inc;
    logic       w_resp;
    logic       w_high;
    logic       w_echo;
    logic       w_done;

    assign w_try_inc = r_try_count + 4'd1;
    assign w_bi_inc  = r_byte_index + 4'd1;
    assign w_resp    = (r_phase == PH_RESP) ||
                       ((r_phase == PH_CMD) && (r_byte_index >= FRAME_END_INDEX));
    assign w_high    = r_high_cap | ((r_byte_index == 4'd0) & i_rx_byte[6]);
    assign w_echo    = (r_byte_index == DATA_LAST_INDEX) ?
                       (i_rx_byte == ECHO_PATTERN) : r_echo;

    // Next state
    always_comb begin
        n_phase      = r_phase;
        n_cmd        = r_cmd;
        n_byte_index = r_byte_index;
        n_try_count  = r_try_count;
        n_poll_count = r_poll_count;
        n_card_kind  = r_card_kind;
        n_selected   = r_selected;
        n_echo       = r_echo;
        n_high_cap   = r_high_cap;
        n_final_ok   = r_final_ok;
        n_final_fail = r_final_fail;
        if (i_start) begin
            n_phase      = PH_CLOCKS;
            n_byte_index = 4'd1;
            n_try_count  = 4'd0;
            n_poll_count = 5'd0;
            n_card_kind  = KIND_UNKNOWN;
            n_selected   = 1'b0;
            n_echo       = 1'b0;
            n_high_cap   = 1'b0;
            n_final_ok   = 1'b0;
            n_final_fail = FAIL_NONE;
        end else if (r_phase == PH_CLOCKS) begin
            if (r_byte_index < INIT_CLOCK_BYTES) begin
                n_byte_index = w_bi_inc;
            end else begin
                n_selected   = 1'b1;
                n_try_count  = 4'd0;
                n_cmd        = CMD_GO_IDLE;
                n_byte_index = 4'd1;
                n_poll_count = 5'd0;
                n_phase      = PH_CMD;
            end
        end else if ((r_phase == PH_CMD) && !w_resp) begin
            // Walk the frame bytes
            n_byte_index = w_bi_inc;
            if (w_bi_inc == FRAME_END_INDEX) begin
                n_phase = PH_RESP;
            end
        end else if (w_resp) begin
            n_phase = PH_RESP;
            if (i_rx_byte[7] && (r_poll_count < i_cfg.poll_limit)) begin
                // Keep polling for R1
                n_poll_count = r_poll_count + 5'd1;
            end else begin
                // Act on R1: default is to start a new command
                n_byte_index = 4'd1;
                n_poll_count = 5'd0;
                n_phase      = PH_CMD;
                case (r_cmd)
                    CMD_GO_IDLE: begin
                        if (i_rx_byte == R1_IDLE) begin
                            n_try_count = 4'd0;
                            n_cmd       = CMD_IF_COND;
                        end else begin
                            n_try_count = w_try_inc;
                            n_cmd       = CMD_GO_IDLE;
                            if (w_try_inc >= i_cfg.go_idle_tries) begin
                                n_phase      = PH_DONE;
                                n_final_fail = FAIL_IDLE;
                                n_selected   = 1'b0;
                                n_byte_index = r_byte_index;
                                n_poll_count = r_poll_count;
                            end
                        end
                    end
                    CMD_IF_COND: begin
                        if (i_rx_byte == R1_IDLE) begin
                            n_phase      = PH_DATA;
                            n_byte_index = 4'd0;
                            n_poll_count = r_poll_count;
                            n_echo       = 1'b0;
                            n_high_cap   = 1'b0;
                        end else if (!i_rx_byte[7] && i_rx_byte[2]) begin
                            n_card_kind = KIND_V1;
                            n_try_count = 4'd0;
                            n_cmd       = CMD_APP;
                        end else begin
                            n_try_count = w_try_inc;
                            n_cmd       = CMD_IF_COND;
                            if (w_try_inc >= i_cfg.interface_tries) begin
                                n_phase      = PH_DONE;
                                n_final_fail = FAIL_IF_COND;
                                n_selected   = 1'b0;
                                n_byte_index = r_byte_index;
                                n_poll_count = r_poll_count;
                            end
                        end
                    end
                    CMD_APP: begin
                        n_cmd = CMD_OP_COND;
                    end
                    CMD_OP_COND: begin
                        if (i_rx_byte == R1_READY) begin
                            if (r_card_kind == KIND_V1) begin
                                n_phase      = PH_DONE;
                                n_final_ok   = 1'b1;
                                n_byte_index = r_byte_index;
                                n_poll_count = r_poll_count;
                            end else begin
                                n_cmd = CMD_READ_OCR;
                            end
                        end else begin
                            n_try_count = w_try_inc;
                            n_cmd       = CMD_APP;
                            if (w_try_inc >= i_cfg.op_cond_tries) begin
                                n_phase      = PH_DONE;
                                n_final_fail = FAIL_OP_COND;
                                n_selected   = 1'b0;
                                n_byte_index = r_byte_index;
                                n_poll_count = r_poll_count;
                            end
                        end
                    end
                    default: begin
                        n_poll_count = r_poll_count;
                        if (i_rx_byte == R1_READY) begin
                            n_phase      = PH_DATA;
                            n_byte_index = 4'd0;
                            n_echo       = 1'b0;
                            n_high_cap   = 1'b0;
                        end else begin
                            n_phase      = PH_DONE;
                            n_final_fail = FAIL_OCR;
                            n_selected   = 1'b0;
                            n_byte_index = r_byte_index;
                        end
                    end
                endcase
            end
        end else if (r_phase == PH_DATA) begin
            // Collect trailing response bytes
            n_high_cap   = w_high;
            n_echo       = w_echo;
            n_byte_index = w_bi_inc;
            if (r_byte_index >= DATA_LAST_INDEX) begin
                if (r_cmd == CMD_IF_COND) begin
                    n_byte_index = 4'd1;
                    n_poll_count = 5'd0;
                    n_phase      = PH_CMD;
                    if (w_echo) begin
                        n_try_count = 4'd0;
                        n_cmd       = CMD_APP;
                    end else begin
                        n_try_count = w_try_inc;
                        n_cmd       = CMD_IF_COND;
                        if (w_try_inc >= i_cfg.interface_tries) begin
                            n_phase      = PH_DONE;
                            n_final_fail = FAIL_IF_COND;
                            n_selected   = 1'b0;
                            n_byte_index = w_bi_inc;
                            n_poll_count = r_poll_count;
                        end
                    end
                end else begin
                    n_card_kind = w_high ? KIND_HC : KIND_V2;
                    n_phase     = PH_DONE;
                    n_final_ok  = 1'b1;
                end
            end
        end
    end

    // Result beat
    always_comb begin
        w_done = (n_phase == PH_IDLE) || (n_phase == PH_DONE);
        o_result.tx_byte = BYTE_IDLE;
        if (!i_start && (r_phase == PH_CMD) && !w_resp) begin
            o_result.tx_byte = frame_byte(r_cmd, r_byte_index[2:0] - 3'd1);
            if (r_byte_index == 4'd1) begin
                o_result.tx_byte = o_result.tx_byte | CMD_START_BIT;
            end
        end
        o_result.chip_select = n_selected;
        o_result.done_res    = w_done;
        o_result.success     = n_final_ok;
        o_result.card_type   = n_card_kind;
        o_result.fail_code   = n_final_fail;
    end

    // Hold state between beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_cmd        <= CMD_GO_IDLE;
            r_byte_index <= 4'd0;
            r_try_count  <= 4'd0;
            r_poll_count <= 5'd0;
            r_card_kind  <= KIND_UNKNOWN;
            r_selected   <= 1'b0;
            r_echo       <= 1'b0;
            r_high_cap   <= 1'b0;
            r_final_ok   <= 1'b0;
            r_final_fail <= FAIL_NONE;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_cmd        <= n_cmd;
            r_byte_index <= n_byte_index;
            r_try_count  <= n_try_count;
            r_poll_count <= n_poll_count;
            r_card_kind  <= n_card_kind;
            r_selected   <= n_selected;
            r_echo       <= n_echo;
            r_high_cap   <= n_high_cap;
            r_final_ok   <= n_final_ok;
            r_final_fail <= n_final_fail;
        end
    end

endmodule

>>> sv/sd_card_spi_init_sequencer.sv
// ----------------------------------------------------------------------------
// sd_card_spi_init_sequencer
// SD card SPI-mode initialization engine, one SPI byte per beat.
// ----------------------------------------------------------------------------
// Use: each slave beat carries either a start request (s_axis_tuser = 1) or
// the byte the card returned while the previous tx byte was shifted out
// (s_axis_tuser = 0, byte in s_axis_tdata). Every slave beat yields exactly
// one master beat: the next byte to shift out with the chip select level, or,
// with m_axis_tuser high, the final status (success, card type, fail code).
// The APB port holds the retry counts and the R1 poll limit; write it only
// while no beat is in flight.
// Path: a beat accepted into the input register is stepped by the core into
// the output register, which drives m_axis_tvalid. Throughput: one beat per
// cycle while the output register is free (m_axis_tready high or no result
// held); the step logic between the two registers is a single pass.
// Stall: while m_axis_tready is low the result holds and the input register
// keeps one more beat; s_axis_tready drops once both are full.
// Reset: both registers empty, sequencer idle, registers at their defaults.
// ----------------------------------------------------------------------------
module sd_card_spi_init_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] operation
    // Master stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] tx_byte, [8] chip_select,
                                        // [9] success, [11:10] card_type,
                                        // [14:12] fail_code, [15] zero
    output logic        m_axis_tuser,   // [0] done_res
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sdi_pkg::*;

    t_cfg       w_cfg;
    t_result    w_result;
    t_result    r_out;
    logic       r_out_valid;
    logic       r_in_valid;
    logic       r_in_start;
    logic [7:0] r_in_rx;
    logic       w_step;

    sdi_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Advance the held beat when the output register is free
    assign w_step        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_step;

    sdi_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_step),
        .i_start   (r_in_start),
        .i_rx_byte (r_in_rx),
        .i_cfg     (w_cfg),
        .o_result  (w_result)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_start <= s_axis_tuser;
            r_in_rx    <= s_axis_tdata;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.fail_code, r_out.card_type, r_out.success,
                            r_out.chip_select, r_out.tx_byte};
    assign m_axis_tuser  = r_out.done_res;

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the SD card SPI-mode init sequencer. A planner plays
// the card: it steps its own copy of the sequencer to choose card replies that
// walk the init flow (idle clocks, go-idle, interface condition with echo,
// app/op-condition loop, OCR read), mixed with busy bytes, wrong replies and
// restarts. A second copy of the sequencer predicts every master beat, which
// the monitor compares field by field. Six register settings are visited,
// including zero and full-scale retry counts and poll limits.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sdi_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int BATCH_BEATS = 120;

    // Sequencer state as tracked by the predictor
    typedef struct packed {
        t_phase     ph;
        logic [3:0] idx;
        logic [3:0] tries;
        logic [4:0] polls;
        logic [1:0] kind;
        logic       sel;
        logic       echo_ok;
        t_cmd       cmd;
        logic       hc;
        logic       ok;
        logic [2:0] fail;
    } t_seq;

    typedef struct packed {
        t_seq    nxt;
        t_result res;
    } t_step;

    typedef struct packed {
        logic       op;
        logic [7:0] rx;
    } t_beat;

    typedef enum logic [1:0] {
        SINK_OPEN, SINK_MOSTLY, SINK_EVERY_THIRD, SINK_SPARSE
    } t_sink;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] rx_byte
    logic        s_axis_tuser = 1'b0;    // [0] operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;           // [7:0] tx_byte, [8] chip_select, [9] success,
                                         // [11:10] card_type, [14:12] fail_code
    logic        m_axis_tuser;           // [0] done_res
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    t_beat   card_bytes[$];    // card replies waiting to be sent
    t_result due_replies[$];   // predicted master beats, oldest first
    t_seq    card_model;       // predictor state, stepped on accepted beats
    t_cfg    cfg_now;          // mirror of the register file
    t_seq    plan_st;          // planner state, stepped as beats are queued
    t_cfg    plan_cfg;

    int n_err = 0;
    int beats_in = 0;
    int beats_out = 0;
    int runs_ok [4];
    int runs_failed [5];
    int send_run, send_gap;
    int sink_cycle;
    t_sink sink_mode;
    int quiet_cycles = 0;

    sd_card_spi_init_sequencer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Byte pos of a command frame: index byte first, CRC byte last
    function automatic logic [7:0] cmd_frame_byte(t_cmd cmd, logic [3:0] pos);
        logic [47:0] frame;
        case (cmd)
            CMD_GO_IDLE: frame = 48'h95_00_00_00_00_00;
            CMD_IF_COND: frame = 48'h87_AA_01_00_00_08;
            CMD_APP:     frame = 48'h65_00_00_00_00_37;
            CMD_OP_COND: frame = 48'h77_00_00_00_40_29;
            default:     frame = 48'hFD_00_00_00_00_3A;
        endcase
        return frame[pos*8 +: 8];
    endfunction

    // Advance the sequencer by one slave beat and form the master beat it causes
    function automatic t_step sequencer_next(t_seq s, t_cfg c, logic op, logic [7:0] rx);
        t_step      o;
        logic [7:0] tx;
        logic       show_status, to_cmd, to_data, to_done, if_retry;
        t_cmd       next_cmd;
        logic [2:0] code;
        tx = BYTE_IDLE;
        show_status = 1'b0;
        to_cmd = 1'b0;
        to_data = 1'b0;
        to_done = 1'b0;
        if_retry = 1'b0;
        next_cmd = CMD_GO_IDLE;
        code = FAIL_NONE;
        if (op) begin
            // start clears selection, kind, counters and the final status
            s = '0;
            s.ph = PH_CLOCKS;
            s.idx = 4'd1;
        end else begin
            case (s.ph)
                PH_CLOCKS: begin
                    if (s.idx < INIT_CLOCK_BYTES) begin
                        s.idx = s.idx + 4'd1;
                    end else begin
                        s.sel = 1'b1;
                        s.tries = 4'd0;
                        to_cmd = 1'b1;
                        next_cmd = CMD_GO_IDLE;
                    end
                end
                PH_CMD, PH_RESP: begin
                    if (s.ph == PH_CMD && s.idx < FRAME_END_INDEX) begin
                        tx = cmd_frame_byte(s.cmd, s.idx - 4'd1);
                        if (s.idx == 4'd1) tx = tx | CMD_START_BIT;
                        s.idx = s.idx + 4'd1;
                        if (s.idx == FRAME_END_INDEX) s.ph = PH_RESP;
                    end else if (rx[7] && s.polls < c.poll_limit) begin
                        // card still busy: poll once more
                        s.ph = PH_RESP;
                        s.polls = s.polls + 5'd1;
                    end else begin
                        s.ph = PH_RESP;
                        case (s.cmd)
                            CMD_GO_IDLE: begin
                                if (rx == R1_IDLE) begin
                                    s.tries = 4'd0;
                                    to_cmd = 1'b1;
                                    next_cmd = CMD_IF_COND;
                                end else begin
                                    s.tries = s.tries + 4'd1;
                                    if (s.tries >= c.go_idle_tries) begin
                                        to_done = 1'b1;
                                        code = FAIL_IDLE;
                                    end else begin
                                        to_cmd = 1'b1;
                                        next_cmd = CMD_GO_IDLE;
                                    end
                                end
                            end
                            CMD_IF_COND: begin
                                // illegal-command bit only counts on a valid R1
                                if (rx == R1_IDLE) begin
                                    to_data = 1'b1;
                                end else if (!rx[7] && rx[2]) begin
                                    s.kind = KIND_V1;
                                    s.tries = 4'd0;
                                    to_cmd = 1'b1;
                                    next_cmd = CMD_APP;
                                end else begin
                                    if_retry = 1'b1;
                                end
                            end
                            CMD_APP: begin
                                to_cmd = 1'b1;
                                next_cmd = CMD_OP_COND;
                            end
                            CMD_OP_COND: begin
                                if (rx == R1_READY) begin
                                    if (s.kind == KIND_V1) begin
                                        to_done = 1'b1;
                                    end else begin
                                        to_cmd = 1'b1;
                                        next_cmd = CMD_READ_OCR;
                                    end
                                end else begin
                                    s.tries = s.tries + 4'd1;
                                    if (s.tries >= c.op_cond_tries) begin
                                        to_done = 1'b1;
                                        code = FAIL_OP_COND;
                                    end else begin
                                        to_cmd = 1'b1;
                                        next_cmd = CMD_APP;
                                    end
                                end
                            end
                            default: begin
                                if (rx == R1_READY) begin
                                    to_data = 1'b1;
                                end else begin
                                    to_done = 1'b1;
                                    code = FAIL_OCR;
                                end
                            end
                        endcase
                    end
                end
                PH_DATA: begin
                    // first trailing byte carries the capacity bit, the last one the echo
                    if (s.idx == 4'd0 && rx[6]) s.hc = 1'b1;
                    if (s.idx == DATA_LAST_INDEX) s.echo_ok = (rx == ECHO_PATTERN);
                    s.idx = s.idx + 4'd1;
                    if (s.idx > DATA_LAST_INDEX) begin
                        if (s.cmd == CMD_IF_COND) begin
                            if (s.echo_ok) begin
                                s.tries = 4'd0;
                                to_cmd = 1'b1;
                                next_cmd = CMD_APP;
                            end else begin
                                if_retry = 1'b1;
                            end
                        end else begin
                            s.kind = s.hc ? KIND_HC : KIND_V2;
                            to_done = 1'b1;
                        end
                    end
                end
                default: show_status = 1'b1;
            endcase
        end
        if (if_retry) begin
            s.tries = s.tries + 4'd1;
            if (s.tries >= c.interface_tries) begin
                to_done = 1'b1;
                code = FAIL_IF_COND;
            end else begin
                to_cmd = 1'b1;
                next_cmd = CMD_IF_COND;
            end
        end
        if (to_cmd) begin
            s.cmd = next_cmd;
            s.idx = 4'd1;
            s.polls = 5'd0;
            s.ph = PH_CMD;
        end
        if (to_data) begin
            s.ph = PH_DATA;
            s.idx = 4'd0;
            s.echo_ok = 1'b0;
            s.hc = 1'b0;
        end
        if (to_done) begin
            // failure drops chip select, success keeps the card selected
            s.ph = PH_DONE;
            s.fail = code;
            s.ok = (code == FAIL_NONE);
            if (code != FAIL_NONE) s.sel = 1'b0;
            show_status = 1'b1;
        end
        o.nxt = s;
        o.res.tx_byte = show_status ? BYTE_IDLE : tx;
        o.res.chip_select = s.sel;
        o.res.done_res = show_status;
        o.res.success = show_status & s.ok;
        o.res.card_type = s.kind;
        o.res.fail_code = show_status ? s.fail : FAIL_NONE;
        return o;
    endfunction

    // Pick what the card returns next, steered by where the sequencer stands
    function automatic logic [7:0] card_reply(t_seq s);
        int         roll;
        logic [7:0] any;
        roll = $urandom_range(0, 99);
        any = 8'($urandom_range(0, 255));
        if (s.ph == PH_RESP) begin
            if (roll < 20) return {1'b1, any[6:0]};
            case (s.cmd)
                CMD_GO_IDLE: return (roll < 80) ? R1_IDLE : any;
                CMD_IF_COND: begin
                    if (roll < 55) return R1_IDLE;
                    if (roll < 80) return {1'b0, any[6:0]} | 8'h04;
                    return any;
                end
                CMD_APP:     return any;
                CMD_OP_COND: begin
                    if (roll < 60) return R1_READY;
                    if (roll < 85) return R1_IDLE;
                    return any;
                end
                default:     return (roll < 85) ? R1_READY : any;
            endcase
        end
        if (s.ph == PH_DATA && s.idx == DATA_LAST_INDEX && roll < 80) return ECHO_PATTERN;
        return any;
    endfunction

    task automatic plan_push(logic op, logic [7:0] rx);
        t_step st;
        t_beat b;
        st = sequencer_next(plan_st, plan_cfg, op, rx);
        plan_st = st.nxt;
        b.op = op;
        b.rx = rx;
        card_bytes.push_back(b);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apb_read_check(logic [1:0] idx, logic [31:0] want);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== want) begin
            n_err++;
            $display("%0t: register %0d readback expected %0h actual %0h",
                     $time, idx, want, prdata);
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(logic [3:0] gi, logic [3:0] itf, logic [3:0] oc, logic [4:0] pl);
        plan_cfg.go_idle_tries = gi;
        plan_cfg.interface_tries = itf;
        plan_cfg.op_cond_tries = oc;
        plan_cfg.poll_limit = pl;
        apb_write(REG_GO_IDLE_TRIES, {28'd0, gi});
        apb_write(REG_INTERFACE_TRIES, {28'd0, itf});
        apb_write(REG_OP_COND_TRIES, {28'd0, oc});
        apb_write(REG_POLL_LIMIT, {27'd0, pl});
        apb_read_check(REG_GO_IDLE_TRIES, {28'd0, gi});
        apb_read_check(REG_INTERFACE_TRIES, {28'd0, itf});
        apb_read_check(REG_OP_COND_TRIES, {28'd0, oc});
        apb_read_check(REG_POLL_LIMIT, {27'd0, pl});
        @(negedge i_clk);
    endtask

    // Hold until every queued beat went in and every predicted beat came out
    task automatic wait_drained();
        @(negedge i_clk);
        while (card_bytes.size() != 0 || s_axis_tvalid || due_replies.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Whole init runs with random card content, some stray bytes and restarts
    task automatic random_batch(int quota);
        int counted;
        counted = 0;
        while (counted < quota) begin
            if (plan_st.ph == PH_IDLE || plan_st.ph == PH_DONE) begin
                repeat ($urandom_range(0, 2)) plan_push(1'b0, 8'($urandom_range(0, 255)));
                plan_push(1'b1, 8'($urandom_range(0, 255)));
            end else if ($urandom_range(0, 99) == 0) begin
                plan_push(1'b1, 8'($urandom_range(0, 255)));
            end else begin
                plan_push(1'b0, card_reply(plan_st));
            end
            counted++;
        end
    endtask

    task automatic check_field(string what, int want, int got);
        if (want != got) begin
            n_err++;
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
        end
    endtask

    // Slave-side driver: bursts of beats separated by random gaps
    always @(posedge i_clk) begin
        t_beat b;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_run = 0;
            send_gap = 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (card_bytes.size() != 0) begin
                b = card_bytes.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= b.rx;
                s_axis_tuser <= b.op;
                if (send_run > 0) begin
                    send_run--;
                end else begin
                    send_run = $urandom_range(1, 24);
                    send_gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Master-side ready: switch between stall patterns every so often
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_cycle = 0;
            sink_mode = SINK_OPEN;
        end else begin
            sink_cycle++;
            if (sink_cycle % 96 == 0) sink_mode = t_sink'($urandom_range(0, 3));
            case (sink_mode)
                SINK_OPEN:        m_axis_tready <= 1'b1;
                SINK_MOSTLY:      m_axis_tready <= ($urandom_range(0, 3) != 0);
                SINK_EVERY_THIRD: m_axis_tready <= (sink_cycle % 3 == 0);
                default:          m_axis_tready <= ($urandom_range(0, 7) < 3);
            endcase
        end
    end

    // Mirror register writes, predict on slave beats, check master beats
    always @(posedge i_clk) begin
        t_step   st;
        t_result want;
        if (!i_rst_n) begin
            card_model = '0;
            cfg_now.go_idle_tries = 4'd8;
            cfg_now.interface_tries = 4'd10;
            cfg_now.op_cond_tries = 4'd8;
            cfg_now.poll_limit = 5'd16;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_GO_IDLE_TRIES:   cfg_now.go_idle_tries = pwdata[3:0];
                    REG_INTERFACE_TRIES: cfg_now.interface_tries = pwdata[3:0];
                    REG_OP_COND_TRIES:   cfg_now.op_cond_tries = pwdata[3:0];
                    default:             cfg_now.poll_limit = pwdata[4:0];
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                st = sequencer_next(card_model, cfg_now, s_axis_tuser, s_axis_tdata);
                if (st.nxt.ph == PH_DONE && card_model.ph != PH_DONE) begin
                    if (st.nxt.ok) runs_ok[st.nxt.kind]++;
                    else runs_failed[st.nxt.fail]++;
                end
                card_model = st.nxt;
                due_replies.push_back(st.res);
                beats_in++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                beats_out++;
                if (due_replies.size() == 0) begin
                    n_err++;
                    $display("%0t: beat expected none actual %0h/%0b",
                             $time, m_axis_tdata, m_axis_tuser);
                end else begin
                    want = due_replies.pop_front();
                    check_field("tx_byte", int'(want.tx_byte), int'(m_axis_tdata[7:0]));
                    check_field("chip_select", int'(want.chip_select),
                                int'(m_axis_tdata[8]));
                    check_field("done_res", int'(want.done_res), int'(m_axis_tuser));
                    check_field("success", int'(want.success), int'(m_axis_tdata[9]));
                    check_field("card_type", int'(want.card_type),
                                int'(m_axis_tdata[11:10]));
                    check_field("fail_code", int'(want.fail_code),
                                int'(m_axis_tdata[14:12]));
                end
            end
        end
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin
        plan_st = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: stray bytes before any start, restart during idle clocks,
        // zero go-idle tries with no polling so one busy R1 ends the run
        configure(4'd0, 4'd10, 4'd8, 5'd0);
        plan_push(1'b0, 8'h00);
        plan_push(1'b0, 8'hFF);
        plan_push(1'b1, 8'hFF);
        repeat (3) plan_push(1'b0, 8'h5A);
        plan_push(1'b1, 8'h00);
        repeat (10) plan_push(1'b0, 8'($urandom_range(0, 255)));
        repeat (6) plan_push(1'b0, 8'hFF);
        plan_push(1'b0, 8'h81);
        plan_push(1'b0, 8'h01);
        plan_push(1'b0, 8'h00);
        wait_drained();

        // Random runs over defaults, minimum, maximum, random and zero tries
        configure(4'd8, 4'd10, 4'd8, 5'd16);
        random_batch(BATCH_BEATS);
        wait_drained();
        configure(4'd1, 4'd1, 4'd1, 5'd0);
        random_batch(BATCH_BEATS);
        wait_drained();
        configure(4'd15, 4'd15, 4'd15, 5'd31);
        random_batch(BATCH_BEATS);
        wait_drained();
        configure(4'($urandom_range(1, 15)), 4'($urandom_range(1, 15)),
                  4'($urandom_range(1, 15)), 5'($urandom_range(0, 31)));
        random_batch(BATCH_BEATS);
        wait_drained();
        configure(4'd0, 4'd0, 4'd0, 5'($urandom_range(0, 31)));
        random_batch(BATCH_BEATS);
        wait_drained();
        repeat (8) @(negedge i_clk);

        $display("summary: %0d beats in, %0d beats checked, 6 register settings",
                 beats_in, beats_out);
        $display("summary: ok v1/v2/hc %0d/%0d/%0d, failed idle/if/op/ocr %0d/%0d/%0d/%0d",
                 runs_ok[KIND_V1], runs_ok[KIND_V2], runs_ok[KIND_HC],
                 runs_failed[FAIL_IDLE], runs_failed[FAIL_IF_COND],
                 runs_failed[FAIL_OP_COND], runs_failed[FAIL_OCR]);
        if (n_err == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
